[rtl/ipbb_pkg.sv]
// Shared constants, sizes and arithmetic helpers for the in-place five-point box blur.
// Used by the top level, its port checker and the testbench; depends on nothing else.
package ipbb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W   = 32;
  localparam int CHAN_W  = 8;
  localparam int NCHAN   = 3;
  localparam int LINE_W  = CHAN_W * NCHAN;
  localparam int CFG_W   = 11;
  localparam int DIM_W   = CFG_W;
  localparam int CNT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int WIN_DEPTH  = MAX_WIDTH + 1;
  localparam int WIN_AW     = $clog2(WIN_DEPTH);
  localparam int LINE_DEPTH = MAX_WIDTH;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int PSUM_W     = CHAN_W + 2;
  localparam int SUM_W      = CHAN_W + 3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam int DIV5_MUL   = 13108;
  localparam int DIV5_SHIFT = 16;
  localparam int DIV5_W     = SUM_W + 14;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } item_kind_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v < CFG_W'(2)) begin
      r = DIM_W'(2);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Floor of s / 5 for s up to five full channel values.
  function automatic logic [CHAN_W-1:0] div5(input logic [SUM_W-1:0] s);
    logic [DIV5_W-1:0] prod;
    prod = DIV5_W'(s) * DIV5_W'(DIV5_MUL);
    return prod[DIV5_SHIFT +: CHAN_W];
  endfunction

endpackage

[rtl/inplace_five_point_box_blur.sv]
// A completing request passes stages B and C into the output queue; results lag by one row.
// Throughput: one request per clock while the output queue has room, set by the window memory
// taking one write and two reads a cycle and by the combinational left-neighbor add and scale.
// Reset (rst_n low, synchronous) clears counters, pipeline, output queue and the left
// neighbor, and sets width 640 and height 480; the window and line memories are not cleared.
// Top level of the in-place five-point box blur; depends on ipbb_pkg.
module inplace_five_point_box_blur (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [ipbb_pkg::PIX_W-1:0]  in_tdata,   // pixel_in
  input  logic [0:0]                  in_tuser,   // kind
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ipbb_pkg::PIX_W-1:0]  out_tdata,  // pixel_out
  output logic                        out_tlast,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [0:0]                  cfg_index,
  input  logic [ipbb_pkg::CFG_W-1:0]  cfg_data
);
  import ipbb_pkg::*;

  // Configuration and frame position.
  logic [DIM_W-1:0]   w_r, h_r, w_nxt, h_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic [CNT_W-1:0]   in_cnt_r, in_cnt_nxt, out_cnt_r, out_cnt_nxt;
  logic [WIN_AW-1:0]  in_wpos_r, in_wpos_nxt, out_spos_r, out_spos_nxt, right_pos;
  logic [LINE_AW-1:0] out_col_r, out_col_nxt;

  logic cfg_wr, acc, frame_done, is_pix, emit_a;
  logic first_row, last_row, last_pix, fwd_a;

  // Stage B.
  logic              vb_r, pass_b_r, end_b_r, fwd_b_r;
  logic [PIX_W-1:0]  down_b_r;
  logic [LINE_AW-1:0] col_b_r;
  logic [PIX_W-1:0]  win_self_rd_r, win_right_rd_r;
  logic [LINE_W-1:0] line_rd_r, up_b;
  logic [NCHAN-1:0][PSUM_W-1:0] psum_b;

  // Stage C.
  logic              vc_r, pass_c_r, end_c_r;
  logic [PIX_W-1:0]  self_c_r;
  logic [LINE_AW-1:0] col_c_r;
  logic [NCHAN-1:0][PSUM_W-1:0] psum_c_r;
  logic [NCHAN-1:0][SUM_W-1:0]  sum_c;
  logic [LINE_W-1:0] blur_c;
  logic [PIX_W-1:0]  res_c;
  logic [LINE_W-1:0] left_r;

  // Memories.
  logic [PIX_W-1:0]  win_mem  [WIN_DEPTH];
  logic [LINE_W-1:0] line_mem [LINE_DEPTH];

  // Output queue.
  logic [PIX_W:0]     fifo_mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] fifo_cnt_r;
  logic [FIFO_CW-1:0] credit;
  logic               push, pop;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign credit    = fifo_cnt_r + FIFO_CW'(vb_r) + FIFO_CW'(vc_r);
  assign in_tready = credit < FIFO_CW'(FIFO_DEPTH);
  assign acc       = in_tvalid && in_tready;

  assign frame_done = in_cnt_r >= total_r;
  assign is_pix     = (in_tuser[0] == KIND_PIXEL) && !frame_done;
  assign emit_a     = acc && (is_pix ? (in_cnt_r >= CNT_W'(w_r))
                                     : (frame_done && (out_cnt_r < in_cnt_r)));

  assign first_row = out_cnt_r < CNT_W'(w_r);
  assign last_row  = (out_cnt_r + CNT_W'(w_r)) >= total_r;
  assign last_pix  = (out_cnt_r + CNT_W'(1)) == total_r;
  assign right_pos = (out_spos_r == WIN_AW'(w_r)) ? '0 : out_spos_r + WIN_AW'(1);
  assign fwd_a     = emit_a && vc_r && (col_c_r == out_col_r);

  always_comb begin
    w_nxt       = w_r;
    h_nxt       = h_r;
    in_cnt_nxt  = in_cnt_r;
    in_wpos_nxt = in_wpos_r;
    out_cnt_nxt = out_cnt_r;
    out_spos_nxt = out_spos_r;
    out_col_nxt = out_col_r;
    if (cfg_wr) begin
      case (cfg_index[0])
        REG_FRAME_WIDTH:  w_nxt = clamp_dim(cfg_data, DIM_W'(MAX_WIDTH));
        REG_FRAME_HEIGHT: h_nxt = clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT));
        default: ;
      endcase
      in_cnt_nxt   = '0;
      in_wpos_nxt  = '0;
      out_cnt_nxt  = '0;
      out_spos_nxt = '0;
      out_col_nxt  = '0;
    end else begin
      if (acc && is_pix) begin
        in_cnt_nxt  = in_cnt_r + CNT_W'(1);
        in_wpos_nxt = (in_wpos_r == WIN_AW'(w_r)) ? '0 : in_wpos_r + WIN_AW'(1);
      end
      if (emit_a) begin
        if (last_pix) begin
          in_cnt_nxt   = '0;
          in_wpos_nxt  = '0;
          out_cnt_nxt  = '0;
          out_spos_nxt = '0;
          out_col_nxt  = '0;
        end else begin
          out_cnt_nxt  = out_cnt_r + CNT_W'(1);
          out_spos_nxt = right_pos;
          out_col_nxt  = ({1'b0, out_col_r} == w_r - DIM_W'(1)) ? '0
                                                                 : out_col_r + LINE_AW'(1);
        end
      end
    end
    total_nxt = CNT_W'({{DIM_W{1'b0}}, w_nxt} * {{DIM_W{1'b0}}, h_nxt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r        <= DIM_W'(640);
      h_r        <= DIM_W'(480);
      total_r    <= CNT_W'(640 * 480);
      in_cnt_r   <= '0;
      in_wpos_r  <= '0;
      out_cnt_r  <= '0;
      out_spos_r <= '0;
      out_col_r  <= '0;
    end else begin
      w_r        <= w_nxt;
      h_r        <= h_nxt;
      total_r    <= total_nxt;
      in_cnt_r   <= in_cnt_nxt;
      in_wpos_r  <= in_wpos_nxt;
      out_cnt_r  <= out_cnt_nxt;
      out_spos_r <= out_spos_nxt;
      out_col_r  <= out_col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && is_pix) begin
      win_mem[in_wpos_r] <= in_tdata;
    end
    win_self_rd_r  <= win_mem[out_spos_r];
    win_right_rd_r <= win_mem[right_pos];
  end

  always_ff @(posedge clk) begin
    if (vc_r) begin
      line_mem[col_c_r] <= res_c[LINE_W-1:0];
    end
    line_rd_r <= line_mem[out_col_r];
  end

  // Stage B: the upper neighbor bypasses the line memory when it was written at the read edge.
  assign up_b = fwd_b_r ? left_r : line_rd_r;

  always_comb begin
    for (int ch = 0; ch < NCHAN; ch++) begin
      psum_b[ch] = PSUM_W'(win_self_rd_r[ch*CHAN_W +: CHAN_W])
                 + PSUM_W'(win_right_rd_r[ch*CHAN_W +: CHAN_W])
                 + PSUM_W'(down_b_r[ch*CHAN_W +: CHAN_W])
                 + PSUM_W'(up_b[ch*CHAN_W +: CHAN_W]);
    end
  end

  // Stage C: add the left neighbor and divide by five, or pass border-row pixels through.
  always_comb begin
    for (int ch = 0; ch < NCHAN; ch++) begin
      sum_c[ch] = SUM_W'(psum_c_r[ch]) + SUM_W'(left_r[ch*CHAN_W +: CHAN_W]);
      blur_c[ch*CHAN_W +: CHAN_W] = div5(sum_c[ch]);
    end
    res_c = pass_c_r ? self_c_r : {{(PIX_W - LINE_W){1'b0}}, blur_c};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r   <= 1'b0;
      vc_r   <= 1'b0;
      left_r <= '0;
    end else begin
      vb_r <= emit_a && !cfg_wr;
      vc_r <= vb_r;
      if (cfg_wr) begin
        left_r <= '0;
      end else if (vc_r) begin
        left_r <= res_c[LINE_W-1:0];
      end
    end
    down_b_r <= in_tdata;
    pass_b_r <= first_row || last_row;
    end_b_r  <= last_pix;
    col_b_r  <= out_col_r;
    fwd_b_r  <= fwd_a;
    psum_c_r <= psum_b;
    self_c_r <= win_self_rd_r;
    pass_c_r <= pass_b_r;
    end_c_r  <= end_b_r;
    col_c_r  <= col_b_r;
  end

  assign push       = vc_r;
  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = fifo_cnt_r != '0;
  assign out_tdata  = fifo_mem_r[rd_ptr_r][PIX_W-1:0];
  assign out_tlast  = fifo_mem_r[rd_ptr_r][PIX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + FIFO_CW'(push) - FIFO_CW'(pop);
    end
    if (push) begin
      fifo_mem_r[wr_ptr_r] <= {end_c_r, res_c};
    end
  end

endmodule

[rtl/ipbb_checker.sv]
// Port-level checker for the in-place five-point box blur, bound to the top level.
// Depends on ipbb_pkg for port widths.
module ipbb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [ipbb_pkg::PIX_W-1:0]  in_tdata,
  input logic [0:0]                  in_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [ipbb_pkg::PIX_W-1:0]  out_tdata,
  input logic                        out_tlast,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [0:0]                  cfg_index,
  input logic [ipbb_pkg::CFG_W-1:0]  cfg_data
);
  import ipbb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result request withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with no result waiting");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 3))
    else $error("result appeared without a request three cycles earlier");

endmodule

bind inplace_five_point_box_blur ipbb_checker u_ipbb_checker (.*);

[tb/blur_stream_checker.sv]
// Stream checker for the in-place five-point box blur: watches the request, result and
// register channels, predicts every result pixel and compares it with what leaves the block.
// Depends on ipbb_pkg for the item kinds, register indexes and size limits.
`timescale 1ns / 1ps

module blur_stream_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [ipbb_pkg::PIX_W-1:0]    in_tdata,   // pixel_in
  input  logic [0:0]                    in_tuser,   // kind
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [ipbb_pkg::PIX_W-1:0]    out_tdata,  // pixel_out
  input  logic                          out_tlast,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [0:0]                    cfg_index,
  input  logic [ipbb_pkg::CFG_W-1:0]    cfg_data,
  output int                            mismatches,
  output int                            results_due
);
  import ipbb_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } blurred_pixel_t;

  blurred_pixel_t   pending_pixels[$];
  blurred_pixel_t   want;

  logic [PIX_W-1:0]  source_ring [0:WIN_DEPTH-1];
  logic [LINE_W-1:0] row_above [0:LINE_DEPTH-1];
  logic [LINE_W-1:0] left_px;
  int unsigned       pixels_taken;
  int unsigned       pixels_given;
  int unsigned       row_len;
  int unsigned       row_count;

  function automatic int unsigned fit_dim(input int unsigned v, input int unsigned maxv);
    if (v < 2) return 2;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] cross_mean(input logic [PIX_W-1:0] center, up, left,
                                                  right, down);
    logic [PIX_W-1:0] acc;
    logic [SUM_W-1:0] s;
    acc = '0;
    for (int k = 0; k < NCHAN; k++) begin
      s = SUM_W'(center[CHAN_W*k +: CHAN_W]) + SUM_W'(up[CHAN_W*k +: CHAN_W]) +
          SUM_W'(left[CHAN_W*k +: CHAN_W]) + SUM_W'(right[CHAN_W*k +: CHAN_W]) +
          SUM_W'(down[CHAN_W*k +: CHAN_W]);
      acc[CHAN_W*k +: CHAN_W] = CHAN_W'(s / 5);
    end
    return acc;
  endfunction

  task automatic emit_blurred();
    int unsigned      total;
    int unsigned      col;
    logic [PIX_W-1:0] center;
    logic [PIX_W-1:0] res;
    blurred_pixel_t   r;
    total  = row_len * row_count;
    col    = pixels_given % row_len;
    center = source_ring[pixels_given % (row_len + 1)];
    if (pixels_given < row_len || pixels_given >= total - row_len) begin
      res = center;
    end else begin
      res = cross_mean(center, {8'h00, row_above[col]}, {8'h00, left_px},
                       source_ring[(pixels_given + 1) % (row_len + 1)],
                       source_ring[(pixels_given + row_len) % (row_len + 1)]);
    end
    row_above[col] = res[LINE_W-1:0];
    left_px        = res[LINE_W-1:0];
    r.pixel        = res;
    r.frame_end    = (pixels_given == total - 1);
    pending_pixels.push_back(r);
    if (r.frame_end) begin
      pixels_taken = 0;
      pixels_given = 0;
    end else begin
      pixels_given++;
    end
  endtask

  task automatic take_request(input item_kind_t kind, input logic [PIX_W-1:0] pix);
    int unsigned total;
    total = row_len * row_count;
    if (kind == KIND_FLUSH || pixels_taken >= total) begin
      if (pixels_taken >= total && pixels_given < pixels_taken) emit_blurred();
    end else begin
      source_ring[pixels_taken % (row_len + 1)] = pix;
      pixels_taken++;
      if (pixels_taken > row_len) emit_blurred();
    end
  endtask

  // Inputs change only at the rising edge, so the falling edge sees the values that the
  // next rising edge will act on.
  always @(negedge clk) begin
    if (!rst_n) begin
      pending_pixels.delete();
      left_px      = '0;
      pixels_taken = 0;
      pixels_given = 0;
      row_len      = 640;
      row_count    = 480;
      mismatches   = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_pixels.size() == 0) begin
          $error("pixel_out: expected nothing, got %h", out_tdata);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          if (want.pixel !== out_tdata) begin
            $error("pixel_out: expected %h, got %h", want.pixel, out_tdata);
            mismatches++;
          end
          if (want.frame_end !== out_tlast) begin
            $error("frame_end: expected %b, got %b", want.frame_end, out_tlast);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (reg_index_t'(cfg_index) == REG_FRAME_WIDTH) begin
          row_len = fit_dim(cfg_data, MAX_WIDTH);
        end else begin
          row_count = fit_dim(cfg_data, MAX_HEIGHT);
        end
        pixels_taken = 0;
        pixels_given = 0;
        left_px      = '0;
      end
      if (in_tvalid && in_tready) take_request(item_kind_t'(in_tuser), in_tdata);
    end
    results_due = pending_pixels.size();
  end

endmodule

[tb/inplace_five_point_box_blur_test.sv]
// Top of the box blur testbench: clock, reset, frame and flush requests, size register
// writes and receiver stalls; the verdict comes from the blur_stream_checker beside the block.
// Depends on ipbb_pkg, inplace_five_point_box_blur and blur_stream_checker.
`timescale 1ns / 1ps

module inplace_five_point_box_blur_test;
  import ipbb_pkg::*;

  localparam int RANDOM_TARGET = 560;
  localparam int HOLD_CYCLES   = 400;
  localparam bit [9*PIX_W-1:0] CROSS_PIX = {
    32'h7F7F7F7F, 32'h80808080, 32'hFFFFFFFF,
    32'h01020304, 32'hFFFFFFFF, 32'hFFFFFFFF,
    32'hFF00FF00, 32'h00FF00FF, 32'hFFFFFFFF
  };

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic [PIX_W-1:0] in_tdata   = '0;
  logic [0:0]       in_tuser   = '0;
  logic             out_tready = 1'b0;
  logic             cfg_valid  = 1'b0;
  logic [0:0]       cfg_index  = '0;
  logic [CFG_W-1:0] cfg_data   = '0;
  logic             in_tready;
  logic             out_tvalid;
  logic [PIX_W-1:0] out_tdata;
  logic             out_tlast;
  logic             cfg_ready;
  int               mismatches;
  int               results_due;

  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic long_hold    = 1'b0;
  int   hold_count   = 0;
  int   frame_w;
  int   frame_h;
  int   useful_items;
  int   frame_no;

  inplace_five_point_box_blur DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  blur_stream_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (long_hold && hold_count < HOLD_CYCLES) begin
      out_tready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
      if (!long_hold) hold_count <= 0;
    end
  end

  function automatic int fit_dim(input int v, input int maxv);
    if (v < 2) return 2;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input item_kind_t kind, input logic [PIX_W-1:0] pix);
    logic taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= pix;
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic go_idle();
    in_tvalid <= 1'b0;
    while (results_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_size(input logic [CFG_W-1:0] raw_w, input logic [CFG_W-1:0] raw_h);
    go_idle();
    write_reg(REG_FRAME_WIDTH, raw_w);
    write_reg(REG_FRAME_HEIGHT, raw_h);
    cfg_valid <= 1'b0;
    frame_w = fit_dim(raw_w, MAX_WIDTH);
    frame_h = fit_dim(raw_h, MAX_HEIGHT);
  endtask

  // A frame may be cut short; the next size write then restarts the block.
  task automatic run_frame(input bit may_abort);
    int npix;
    int stop_at;
    npix    = frame_w * frame_h;
    stop_at = npix;
    if (may_abort && $urandom_range(7) == 0) stop_at = $urandom_range(npix - 1, 1);
    for (int i = 0; i < stop_at; i++) begin
      if ($urandom_range(11) == 0) send_item(KIND_FLUSH, $urandom);
      send_item(KIND_PIXEL, pick_pixel());
      useful_items++;
    end
    if (stop_at < npix) return;
    for (int i = 0; i < frame_w; i++) begin
      if ($urandom_range(3) == 0) begin
        send_item(KIND_PIXEL, pick_pixel());
      end else begin
        send_item(KIND_FLUSH, $urandom);
      end
      useful_items++;
    end
    if ($urandom_range(5) == 0) send_item(KIND_FLUSH, $urandom);
  endtask

  initial begin
    #12_000_000;
    $display("inplace_five_point_box_blur_test: errors");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] raw_w;
    logic [CFG_W-1:0] raw_h;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A partial frame at the reset size, including a flush that comes too early.
    send_item(KIND_PIXEL, 32'hFFFFFFFF);
    send_item(KIND_FLUSH, 32'h0);
    send_item(KIND_PIXEL, 32'h12345678);

    // Sizes below the minimum clamp to two; a pixel past the frame end drains like a flush.
    set_size(11'd0, 11'd1);
    send_item(KIND_PIXEL, 32'hFFFFFFFF);
    send_item(KIND_PIXEL, 32'h00000000);
    send_item(KIND_PIXEL, 32'hAAAAAAAA);
    send_item(KIND_PIXEL, 32'h55555555);
    send_item(KIND_FLUSH, 32'h0);
    send_item(KIND_PIXEL, 32'h0F0F0F0F);
    send_item(KIND_FLUSH, 32'hFFFFFFFF);

    set_size(11'd3, 11'd3);
    for (int i = 0; i < 9; i++) send_item(KIND_PIXEL, CROSS_PIX[PIX_W*i +: PIX_W]);
    repeat (3) send_item(KIND_FLUSH, 32'h0);

    // A wide frame with the receiver held off so that the block backs up.
    set_size(11'd30, 11'd3);
    long_hold <= 1'b1;
    run_frame(1'b0);
    go_idle();
    long_hold <= 1'b0;

    tx_idle_pct = 19;
    rx_stall_pct <= 19;
    set_size(11'd2, 11'd40);
    run_frame(1'b0);

    useful_items = 0;
    frame_no = 0;
    while (useful_items < RANDOM_TARGET) begin
      case (frame_no % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct = 76;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 76;
        end
        default: begin
          tx_idle_pct = 19;
          rx_stall_pct <= 19;
        end
      endcase
      if (frame_no == 0 || $urandom_range(3) != 0) begin
        raw_w = $urandom_range(9, 2);
        raw_h = $urandom_range(6, 2);
        if ($urandom_range(15) == 0) raw_w = $urandom_range(1, 0);
        if ($urandom_range(15) == 0) raw_w = $urandom_range(48, 10);
        if ($urandom_range(15) == 0) raw_h = $urandom_range(1, 0);
        set_size(raw_w, raw_h);
      end
      run_frame(1'b1);
      frame_no++;
    end

    go_idle();
    if (mismatches == 0 && results_due == 0) begin
      $display("inplace_five_point_box_blur_test: clean");
    end else begin
      $display("inplace_five_point_box_blur_test: errors");
    end
    $finish;
  end

endmodule
